// File: src/pct_pkg.sv
package pct_pkg;

	localparam int PIXEL_BITS = 8;
	localparam int GAIN_W     = 16;
	localparam int OFFSET_W   = 21;
	localparam int CFG_IDX_W  = 3;

	// Internal value widths, sized for the worst case over all inputs and registers
	localparam int LMS1_W = 18;
	localparam int LAB1_W = 18;
	localparam int T_W    = 35;
	localparam int LAB2_W = 27;
	localparam int LMS2_W = 28;

	localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(256);
	localparam logic [OFFSET_W-1:0] OFFSET_RESET = '0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_L       = 3'd0,
		REG_GAIN_ALPHA   = 3'd1,
		REG_GAIN_BETA    = 3'd2,
		REG_OFFSET_L     = 3'd3,
		REG_OFFSET_ALPHA = 3'd4,
		REG_OFFSET_BETA  = 3'd5
	} cfg_reg_t;

	// Channel 0 lightness, 1 alpha, 2 beta
	typedef struct packed {
		logic [2:0][GAIN_W-1:0]   gain;
		logic [2:0][OFFSET_W-1:0] offset;
	} xfer_cfg_t;

	// Matrix coefficients in units of 1e-4, row major
	localparam int K_RGB_LMS [9] = '{3811, 5783, 402, 1967, 7244, 782, 241, 1288, 8444};
	localparam int K_LMS_LAB [9] = '{5773, 5773, 5773, 4082, 4082, -8165, 7071, -7071, 0};
	localparam int K_LAB_LMS [9] = '{5773, 4082, 7071, 5773, 4082, -7071, 5773, -8165, 0};
	localparam int K_LMS_RGB [9] =
		'{44679, -35873, 1193, -12186, 23809, -1624, 497, -2439, 12045};

	// Quantise a coefficient to frac bits, ties away from zero
	function automatic longint quant_coef(input int c, input int frac);
		longint mag;
		mag = (c < 0) ? -longint'(c) : longint'(c);
		mag = ((mag << frac) + 64'sd5000) / 64'sd10000;
		return (c < 0) ? -mag : mag;
	endfunction

endpackage

// File: src/pct_cfg_regs.sv
module pct_cfg_regs (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pct_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [pct_pkg::OFFSET_W-1:0]          cfg_data,
	output pct_pkg::xfer_cfg_t                    cfg
);

	pct_pkg::xfer_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				cfg_q.gain[i]   <= pct_pkg::GAIN_RESET;
				cfg_q.offset[i] <= pct_pkg::OFFSET_RESET;
			end
		end else if (cfg_valid) begin
			unique case (pct_pkg::cfg_reg_t'(cfg_index))
				pct_pkg::REG_GAIN_L:       cfg_q.gain[0]   <= cfg_data[pct_pkg::GAIN_W-1:0];
				pct_pkg::REG_GAIN_ALPHA:   cfg_q.gain[1]   <= cfg_data[pct_pkg::GAIN_W-1:0];
				pct_pkg::REG_GAIN_BETA:    cfg_q.gain[2]   <= cfg_data[pct_pkg::GAIN_W-1:0];
				pct_pkg::REG_OFFSET_L:     cfg_q.offset[0] <= cfg_data;
				pct_pkg::REG_OFFSET_ALPHA: cfg_q.offset[1] <= cfg_data;
				pct_pkg::REG_OFFSET_BETA:  cfg_q.offset[2] <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// File: src/pixel_color_transfer_top.sv
// Colour transfer of one RGB pixel per beat through the l-alpha-beta space.
// Input channel: in_valid/in_ready carrying red_in, green_in, blue_in.
// Output channel: out_valid/out_ready carrying red_out, green_out, blue_out.
// Configuration channel: cfg_valid/cfg_ready with cfg_index (0..5: gain_l,
// gain_alpha, gain_beta, offset_l, offset_alpha, offset_beta) and cfg_data;
// gains are Q8.8 in the low 16 bits, offsets signed Q13.8. Other indexes are
// dropped. Write configuration only while no pixel is in flight.
// Throughput: one pixel per cycle while the receiver does not stall, set
// by the seven-stage pipeline (two matrix stages, the gain/offset stage, and
// two stages each for the two wide matrices: products, then sums).
// Each stage holds while the stage after it is full and stalled, so a stalled
// receiver backs the pipeline up one stage at a time and nothing is lost;
// in_ready stays high while any stage has a bubble.
// Reset empties the pipeline and sets gains to 1.0 and offsets to zero.
module pixel_color_transfer_top #(
	parameter int COEF_FRAC_BITS = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [pct_pkg::PIXEL_BITS-1:0]       red_in,
	input  logic [pct_pkg::PIXEL_BITS-1:0]       green_in,
	input  logic [pct_pkg::PIXEL_BITS-1:0]       blue_in,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [pct_pkg::PIXEL_BITS-1:0]       red_out,
	output logic [pct_pkg::PIXEL_BITS-1:0]       green_out,
	output logic [pct_pkg::PIXEL_BITS-1:0]       blue_out,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pct_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pct_pkg::OFFSET_W-1:0]         cfg_data
);

	localparam int F    = COEF_FRAC_BITS;
	localparam int CW   = F + 4;
	localparam int PB   = pct_pkg::PIXEL_BITS;
	localparam int A1_W = PB + 1 + CW + 2;
	localparam int A2_W = pct_pkg::LMS1_W + CW + 2;
	localparam int P4_W = pct_pkg::LAB2_W + CW;
	localparam int A5_W = P4_W + 2;
	localparam int P6_W = pct_pkg::LMS2_W + CW;
	localparam int A7_W = P6_W + 2;
	localparam int TW   = pct_pkg::T_W;
	localparam int SH1  = F - 8;
	localparam longint RND1 = (SH1 > 0) ? (longint'(1) << (SH1 - 1)) : longint'(0);
	localparam longint RNDF = longint'(1) << (F - 1);
	localparam longint PIX_MAX = (longint'(1) << PB) - 1;

	function automatic logic [9*CW-1:0] pack_coefs(input int k [9]);
		logic [9*CW-1:0] m;
		for (int i = 0; i < 9; i++)
			m[i*CW +: CW] = CW'(pct_pkg::quant_coef(k[i], F));
		return m;
	endfunction

	function automatic logic signed [CW-1:0] kc(input logic [9*CW-1:0] m, input int i);
		return $signed(m[i*CW +: CW]);
	endfunction

	localparam logic [9*CW-1:0] C_RGB_LMS = pack_coefs(pct_pkg::K_RGB_LMS);
	localparam logic [9*CW-1:0] C_LMS_LAB = pack_coefs(pct_pkg::K_LMS_LAB);
	localparam logic [9*CW-1:0] C_LAB_LMS = pack_coefs(pct_pkg::K_LAB_LMS);
	localparam logic [9*CW-1:0] C_LMS_RGB = pack_coefs(pct_pkg::K_LMS_RGB);

	pct_pkg::xfer_cfg_t cfg;

	pct_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Handshake chain: a stage takes a beat when empty or when it hands on
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic ready_s1, ready_s2, ready_s3, ready_s4, ready_s5, ready_s6, ready_s7;

	assign ready_s7 = !valid_s7 || out_ready;
	assign ready_s6 = !valid_s6 || ready_s7;
	assign ready_s5 = !valid_s5 || ready_s6;
	assign ready_s4 = !valid_s4 || ready_s5;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;
	assign out_valid = valid_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
			if (ready_s5) valid_s5 <= valid_s4;
			if (ready_s6) valid_s6 <= valid_s5;
			if (ready_s7) valid_s7 <= valid_s6;
		end
	end

	// Stage 1: RGB to LMS, rounded to Q.8
	logic signed [A1_W-1:0] rgb_ext [3];
	logic signed [A1_W-1:0] acc1 [3];
	logic signed [pct_pkg::LMS1_W-1:0] lms1_d [3];
	logic signed [pct_pkg::LMS1_W-1:0] lms1_s1 [3];

	assign rgb_ext[0] = $signed(A1_W'(red_in));
	assign rgb_ext[1] = $signed(A1_W'(green_in));
	assign rgb_ext[2] = $signed(A1_W'(blue_in));

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc1[r] = '0;
			for (int c = 0; c < 3; c++)
				acc1[r] = acc1[r] + rgb_ext[c] * A1_W'(kc(C_RGB_LMS, r*3 + c));
			lms1_d[r] = pct_pkg::LMS1_W'((acc1[r] + A1_W'(RND1)) >>> SH1);
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) lms1_s1 <= lms1_d;
	end

	// Stage 2: LMS to lab
	logic signed [A2_W-1:0] acc2 [3];
	logic signed [pct_pkg::LAB1_W-1:0] lab1_d [3];
	logic signed [pct_pkg::LAB1_W-1:0] lab1_s2 [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc2[r] = '0;
			for (int c = 0; c < 3; c++)
				acc2[r] = acc2[r] + A2_W'(lms1_s1[c]) * A2_W'(kc(C_LMS_LAB, r*3 + c));
			lab1_d[r] = pct_pkg::LAB1_W'((acc2[r] + A2_W'(RNDF)) >>> F);
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) lab1_s2 <= lab1_d;
	end

	// Stage 3: gain and offset per channel, rounded back to Q.8
	logic signed [TW-1:0] t3 [3];
	logic signed [pct_pkg::LAB2_W-1:0] lab2_d [3];
	logic signed [pct_pkg::LAB2_W-1:0] lab2_s3 [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			t3[k] = TW'(lab1_s2[k]) * $signed(TW'(cfg.gain[k]))
				+ (TW'($signed(cfg.offset[k])) <<< 8);
			lab2_d[k] = pct_pkg::LAB2_W'((t3[k] + TW'(128)) >>> 8);
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) lab2_s3 <= lab2_d;
	end

	// Stage 4: lab to LMS products
	logic signed [P4_W-1:0] prod4_s4 [9];

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					prod4_s4[r*3 + c] <= P4_W'(lab2_s3[c]) * P4_W'(kc(C_LAB_LMS, r*3 + c));
		end
	end

	// Stage 5: lab to LMS sums
	logic signed [A5_W-1:0] acc5 [3];
	logic signed [pct_pkg::LMS2_W-1:0] lms2_d [3];
	logic signed [pct_pkg::LMS2_W-1:0] lms2_s5 [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc5[r] = A5_W'(prod4_s4[r*3]) + A5_W'(prod4_s4[r*3 + 1])
				+ A5_W'(prod4_s4[r*3 + 2]);
			lms2_d[r] = pct_pkg::LMS2_W'((acc5[r] + A5_W'(RNDF)) >>> F);
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s5 && valid_s4) lms2_s5 <= lms2_d;
	end

	// Stage 6: LMS to RGB products
	logic signed [P6_W-1:0] prod6_s6 [9];

	always_ff @(posedge clk) begin
		if (ready_s6 && valid_s5) begin
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					prod6_s6[r*3 + c] <= P6_W'(lms2_s5[c]) * P6_W'(kc(C_LMS_RGB, r*3 + c));
		end
	end

	// Stage 7: sum, floor to integer, clamp
	logic signed [A7_W-1:0] acc7 [3];
	logic signed [A7_W-1:0] pix7 [3];
	logic [PB-1:0] rgb_d [3];
	logic [PB-1:0] rgb_s7 [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc7[r] = A7_W'(prod6_s6[r*3]) + A7_W'(prod6_s6[r*3 + 1])
				+ A7_W'(prod6_s6[r*3 + 2]);
			pix7[r] = acc7[r] >>> (F + 8);
			if (pix7[r] < 0)
				rgb_d[r] = '0;
			else if (pix7[r] > A7_W'(PIX_MAX))
				rgb_d[r] = PB'(PIX_MAX);
			else
				rgb_d[r] = pix7[r][PB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s7 && valid_s6) rgb_s7 <= rgb_d;
	end

	assign red_out   = rgb_s7[0];
	assign green_out = rgb_s7[1];
	assign blue_out  = rgb_s7[2];

	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output stage");

	a_beat_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted beat missing from stage 1");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s2 |=> valid_s1)
		else $error("stage 1 beat dropped under stall");

	a_beat_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 && ready_s7 |=> out_valid)
		else $error("stage 6 beat missing from output stage");

endmodule

// File: verif/tb_top.sv
module tb_top;

	localparam int COEF_FRAC   = 12;
	localparam int PIXEL_MAX   = (1 << pct_pkg::PIXEL_BITS) - 1;
	localparam int CYCLE_LIMIT = 400000;
	localparam int STALL_LEN   = 300;
	localparam int PRINT_CAP   = 50;

	// Indexes past the register list: the block drops these writes
	localparam logic [pct_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [pct_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	// Colour matrices in units of 1e-4, row major
	localparam int RGB_TO_LMS [9] = '{3811, 5783, 402, 1967, 7244, 782, 241, 1288, 8444};
	localparam int LMS_TO_LAB [9] = '{5773, 5773, 5773, 4082, 4082, -8165, 7071, -7071, 0};
	localparam int LAB_TO_LMS [9] = '{5773, 4082, 7071, 5773, 4082, -7071, 5773, -8165, 0};
	localparam int LMS_TO_RGB [9] =
		'{44679, -35873, 1193, -12186, 23809, -1624, 497, -2439, 12045};

	typedef struct packed {
		logic [pct_pkg::PIXEL_BITS-1:0] red;
		logic [pct_pkg::PIXEL_BITS-1:0] green;
		logic [pct_pkg::PIXEL_BITS-1:0] blue;
	} rgb_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [pct_pkg::PIXEL_BITS-1:0] red_in = '0;
	logic [pct_pkg::PIXEL_BITS-1:0] green_in = '0;
	logic [pct_pkg::PIXEL_BITS-1:0] blue_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [pct_pkg::PIXEL_BITS-1:0] red_out;
	logic [pct_pkg::PIXEL_BITS-1:0] green_out;
	logic [pct_pkg::PIXEL_BITS-1:0] blue_out;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [pct_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pct_pkg::OFFSET_W-1:0] cfg_data = '0;

	// Channel settings as the block should hold them: 0 lightness, 1 alpha, 2 beta
	logic [pct_pkg::GAIN_W-1:0] gain_set [3] =
		'{pct_pkg::GAIN_RESET, pct_pkg::GAIN_RESET, pct_pkg::GAIN_RESET};
	logic signed [pct_pkg::OFFSET_W-1:0] offset_set [3] = '{'0, '0, '0};

	rgb_t target_pixels [$];
	rgb_t transferred_q [$];

	int send_idle_pct = 13;
	int recv_idle_pct = 86;
	bit stall_armed = 1'b0;
	bit stall_done = 1'b0;
	int hold_left = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	pixel_color_transfer_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// round(c * 2^COEF_FRAC / 1e4), ties away from zero
	function automatic longint coef_q(input int c);
		longint mag;
		mag = (c < 0) ? -longint'(c) : longint'(c);
		mag = ((mag <<< (COEF_FRAC + 1)) + 64'sd10000) / 64'sd20000;
		return (c < 0) ? -mag : mag;
	endfunction

	function automatic longint dot3(input int c0, input int c1, input int c2,
			input longint a0, input longint a1, input longint a2);
		return coef_q(c0) * a0 + coef_q(c1) * a1 + coef_q(c2) * a2;
	endfunction

	// add half an LSB, then floor
	function automatic longint round_half_up(input longint x, input int s);
		return (x + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic rgb_t transfer_colour(input rgb_t px);
		longint va [3];
		longint vb [3];
		longint acc;
		rgb_t res;
		int k;
		va[0] = longint'(px.red);
		va[1] = longint'(px.green);
		va[2] = longint'(px.blue);
		for (k = 0; k < 3; k++) begin
			acc = dot3(RGB_TO_LMS[3*k], RGB_TO_LMS[3*k+1], RGB_TO_LMS[3*k+2],
				va[0], va[1], va[2]);
			vb[k] = round_half_up(acc, COEF_FRAC - 8);
		end
		for (k = 0; k < 3; k++) begin
			acc = dot3(LMS_TO_LAB[3*k], LMS_TO_LAB[3*k+1], LMS_TO_LAB[3*k+2],
				vb[0], vb[1], vb[2]);
			va[k] = round_half_up(acc, COEF_FRAC);
		end
		// gain is Q8.8, offset Q13.8 lifted to Q.16
		for (k = 0; k < 3; k++) begin
			acc = va[k] * longint'(gain_set[k]) + longint'(offset_set[k]) * 256;
			vb[k] = round_half_up(acc, 8);
		end
		for (k = 0; k < 3; k++) begin
			acc = dot3(LAB_TO_LMS[3*k], LAB_TO_LMS[3*k+1], LAB_TO_LMS[3*k+2],
				vb[0], vb[1], vb[2]);
			va[k] = round_half_up(acc, COEF_FRAC);
		end
		for (k = 0; k < 3; k++) begin
			acc = dot3(LMS_TO_RGB[3*k], LMS_TO_RGB[3*k+1], LMS_TO_RGB[3*k+2],
				va[0], va[1], va[2]);
			acc = acc >>> (COEF_FRAC + 8);
			if (acc < 0)
				acc = 0;
			else if (acc > PIXEL_MAX)
				acc = PIXEL_MAX;
			vb[k] = acc;
		end
		res.red   = vb[0][pct_pkg::PIXEL_BITS-1:0];
		res.green = vb[1][pct_pkg::PIXEL_BITS-1:0];
		res.blue  = vb[2][pct_pkg::PIXEL_BITS-1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_CAP)
			$display("[%0d] mismatch: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	task automatic write_reg(input logic [pct_pkg::CFG_IDX_W-1:0] idx,
			input logic [pct_pkg::OFFSET_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			pct_pkg::REG_GAIN_L:       gain_set[0] = data[pct_pkg::GAIN_W-1:0];
			pct_pkg::REG_GAIN_ALPHA:   gain_set[1] = data[pct_pkg::GAIN_W-1:0];
			pct_pkg::REG_GAIN_BETA:    gain_set[2] = data[pct_pkg::GAIN_W-1:0];
			pct_pkg::REG_OFFSET_L:     offset_set[0] = data;
			pct_pkg::REG_OFFSET_ALPHA: offset_set[1] = data;
			pct_pkg::REG_OFFSET_BETA:  offset_set[2] = data;
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	// hold until every queued pixel has gone in and every result has come back
	task automatic drain();
		@(negedge clk);
		while (target_pixels.size() != 0 || in_valid || transferred_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic queue_random(input int count);
		int i;
		for (i = 0; i < count; i++)
			target_pixels.push_back(rgb_t'((3*pct_pkg::PIXEL_BITS)'($urandom())));
	endtask

	task automatic write_all(input logic [pct_pkg::GAIN_W-1:0] gain,
			input logic [pct_pkg::OFFSET_W-1:0] offset);
		write_reg(pct_pkg::REG_GAIN_L,
			{{(pct_pkg::OFFSET_W-pct_pkg::GAIN_W){1'b1}}, gain});
		write_reg(pct_pkg::REG_GAIN_ALPHA,
			{{(pct_pkg::OFFSET_W-pct_pkg::GAIN_W){1'b0}}, gain});
		write_reg(pct_pkg::REG_GAIN_BETA,
			{{(pct_pkg::OFFSET_W-pct_pkg::GAIN_W){1'b1}}, gain});
		write_reg(pct_pkg::REG_OFFSET_L, offset);
		write_reg(pct_pkg::REG_OFFSET_ALPHA, offset);
		write_reg(pct_pkg::REG_OFFSET_BETA, offset);
	endtask

	// driver: offer pending pixels, hold each beat until accepted
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				transferred_q.push_back(transfer_colour({red_in, green_in, blue_in}));
			if (!in_valid || in_ready) begin
				if (target_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					{red_in, green_in, blue_in} <= target_pixels.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result beat against the oldest expected colour
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (transferred_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result %02h %02h %02h",
					red_out, green_out, blue_out));
			end else begin
				if (red_out !== transferred_q[0].red)
					report_mismatch($sformatf("red %02h, want %02h",
						red_out, transferred_q[0].red));
				if (green_out !== transferred_q[0].green)
					report_mismatch($sformatf("green %02h, want %02h",
						green_out, transferred_q[0].green));
				if (blue_out !== transferred_q[0].blue)
					report_mismatch($sformatf("blue %02h, want %02h",
						blue_out, transferred_q[0].blue));
				void'(transferred_q.pop_front());
			end
		end
		if (stall_armed && !stall_done) begin
			hold_left <= STALL_LEN;
			stall_done <= 1'b1;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("pixel_color_transfer_top regression: fail");
			$finish;
		end
	end

	initial begin
		int p;
		int ofs;
		logic [pct_pkg::GAIN_W-1:0] g;
		logic [pct_pkg::OFFSET_W-1:0] o;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: corners, primaries, greys, alternating bits, near-black
		@(negedge clk);
		target_pixels.push_back('{8'h00, 8'h00, 8'h00});
		target_pixels.push_back('{8'hFF, 8'hFF, 8'hFF});
		target_pixels.push_back('{8'hFF, 8'h00, 8'h00});
		target_pixels.push_back('{8'h00, 8'hFF, 8'h00});
		target_pixels.push_back('{8'h00, 8'h00, 8'hFF});
		target_pixels.push_back('{8'hFF, 8'hFF, 8'h00});
		target_pixels.push_back('{8'h00, 8'hFF, 8'hFF});
		target_pixels.push_back('{8'hFF, 8'h00, 8'hFF});
		target_pixels.push_back('{8'h80, 8'h80, 8'h80});
		target_pixels.push_back('{8'h7F, 8'h7F, 8'h7F});
		target_pixels.push_back('{8'h55, 8'hAA, 8'h55});
		target_pixels.push_back('{8'hAA, 8'h55, 8'hAA});
		target_pixels.push_back('{8'h01, 8'h02, 8'h03});
		drain();

		// zero gains, with bits above the gain width set for lightness and beta, most
		// negative offsets, then writes to spare indexes that must change nothing
		write_all(16'h0000, 21'h100000);
		write_reg(REG_SPARE_A, 21'h0FFFFF);
		write_reg(REG_SPARE_B, 21'h1FFFFF);
		@(negedge clk);
		queue_random(30);
		drain();

		// largest gains and offsets drive every channel into saturation
		write_all(16'hFFFF, 21'h0FFFFF);
		@(negedge clk);
		target_pixels.push_back('{8'h00, 8'h00, 8'h00});
		target_pixels.push_back('{8'hFF, 8'hFF, 8'hFF});
		queue_random(30);
		drain();

		for (p = 0; p < 8; p++) begin
			if (p < 3) begin
				send_idle_pct = 13;
				recv_idle_pct = 86;
			end else if (p < 6) begin
				send_idle_pct = 86;
				recv_idle_pct = 13;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (p % 4 == 3) begin
				write_reg(pct_pkg::REG_GAIN_L,
					pct_pkg::OFFSET_W'($urandom_range(0, 65535)));
				write_reg(pct_pkg::REG_GAIN_ALPHA,
					pct_pkg::OFFSET_W'($urandom_range(0, 65535)));
				write_reg(pct_pkg::REG_GAIN_BETA,
					pct_pkg::OFFSET_W'($urandom_range(0, 65535)));
				write_reg(pct_pkg::REG_OFFSET_L,
					pct_pkg::OFFSET_W'($urandom_range(0, 2097151)));
				write_reg(pct_pkg::REG_OFFSET_ALPHA,
					pct_pkg::OFFSET_W'($urandom_range(0, 2097151)));
				write_reg(pct_pkg::REG_OFFSET_BETA,
					pct_pkg::OFFSET_W'($urandom_range(0, 2097151)));
			end else begin
				// plausible statistics: gain near one, modest offsets
				g = pct_pkg::GAIN_W'($urandom_range(64, 1024));
				write_reg(pct_pkg::REG_GAIN_L, {5'($urandom()), g});
				g = pct_pkg::GAIN_W'($urandom_range(64, 1024));
				write_reg(pct_pkg::REG_GAIN_ALPHA, {5'($urandom()), g});
				g = pct_pkg::GAIN_W'($urandom_range(64, 1024));
				write_reg(pct_pkg::REG_GAIN_BETA, {5'($urandom()), g});
				ofs = $urandom_range(0, 24576) - 12288;
				o = ofs[pct_pkg::OFFSET_W-1:0];
				write_reg(pct_pkg::REG_OFFSET_L, o);
				ofs = $urandom_range(0, 24576) - 12288;
				o = ofs[pct_pkg::OFFSET_W-1:0];
				write_reg(pct_pkg::REG_OFFSET_ALPHA, o);
				ofs = $urandom_range(0, 24576) - 12288;
				o = ofs[pct_pkg::OFFSET_W-1:0];
				write_reg(pct_pkg::REG_OFFSET_BETA, o);
			end
			@(negedge clk);
			queue_random(60);
			// long receiver hold-off while the sender keeps offering: pipeline backs up
			if (p == 7)
				stall_armed = 1'b1;
			drain();
		end

		repeat (20) @(negedge clk);
		if (mismatch_count == 0)
			$display("pixel_color_transfer_top regression: pass");
		else
			$display("pixel_color_transfer_top regression: fail");
		$finish;
	end

endmodule
